// ===== src/scs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_pkg
// Shared widths, coefficient codes and the result pair type of the sparse
// challenge sampler.
// ----------------------------------------------------------------------------
package scs_pkg;

  localparam int unsigned COEFF_COUNT_DEF = 256;
  localparam int unsigned SIGN_BYTES      = 8;
  localparam int unsigned KAPPA_MAX       = 64;
  localparam int unsigned KAPPA_RST       = 60;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned VAL_W   = 2;
  localparam int unsigned PIDX_W  = 9;
  localparam int unsigned KAPPA_W = 7;
  localparam int unsigned SCNT_W  = 4;
  localparam int unsigned SIGN_W  = 64;
  localparam int unsigned OUT_PAD = 16 - IDX_W - VAL_W;

  // Coefficient codes, two's complement
  localparam logic [VAL_W-1:0] COEFF_ZERO = 2'b00;
  localparam logic [VAL_W-1:0] COEFF_POS  = 2'b01;
  localparam logic [VAL_W-1:0] COEFF_NEG  = 2'b11;

  // Both writes caused by one accepted position byte
  typedef struct packed {
    logic [IDX_W-1:0] idx_a;   // place index i
    logic [VAL_W-1:0] val_a;   // old c[b]
    logic [IDX_W-1:0] idx_b;   // candidate b
    logic [VAL_W-1:0] val_b;   // sign value
    logic             done;
  } pair_t;

endpackage

// ===== src/sparse_challenge_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_challenge_sampler
// Builds a sparse +/-1 challenge from a stream of hash bytes (sample in ball).
// ----------------------------------------------------------------------------
// Pipeline: a position byte accepted into the read stage resolves old c[b] and
//   is pushed as a pair into the result queue, which presents its first write;
//   the second write follows once the first is taken.
// Flow: no byte is accepted while a position byte is in the read stage or the
//   result queue is full; each position byte makes two writes through the single
//   write port of the coefficient RAM. Sign, rejected and ignored bytes write none.
// Reset: asynchronous, active low; kappa returns to 60 and the coefficient
//   store reads as all zero through its per-entry valid bits, no sweep.
// ----------------------------------------------------------------------------
module sparse_challenge_sampler #(
  parameter int unsigned COEFF_COUNT = scs_pkg::COEFF_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration: kappa
  input  logic                        cfg_we_i,
  input  logic [scs_pkg::KAPPA_W-1:0] cfg_wdata_i,
  // byte stream in
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] stream_byte
  input  logic                        s_axis_tuser,   // [0] first_byte
  // coefficient writes out
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata,   // [7:0] coeff_index,
                                                      // [9:8] coeff_value
  output logic                        m_axis_tlast,   // second write of a byte
  output logic                        m_axis_tuser    // [0] complete
);
  import scs_pkg::*;

  localparam int unsigned AW     = $clog2(COEFF_COUNT);
  localparam int unsigned LIM    = (COEFF_COUNT < KAPPA_MAX) ? COEFF_COUNT : KAPPA_MAX;
  localparam int unsigned RST_K  = (KAPPA_RST > LIM) ? LIM : KAPPA_RST;
  localparam logic [PIDX_W-1:0] PIDX_END  = PIDX_W'(COEFF_COUNT);
  localparam logic [PIDX_W-1:0] PIDX_LAST = PIDX_W'(COEFF_COUNT - 1);
  localparam logic [PIDX_W-1:0] PIDX_RST  = PIDX_W'(COEFF_COUNT - RST_K);

  // --------------------------------------------------------------------------
  // Accept side
  // --------------------------------------------------------------------------
  logic              in_acc;
  logic              first_acc;
  logic [BYTE_W-1:0] byte_b;

  // challenge state
  logic [KAPPA_W-1:0] kappa_q;
  logic [SIGN_W-1:0]  sign_q, sign_d;
  logic [SCNT_W-1:0]  scnt_q, scnt_d;
  logic [PIDX_W-1:0]  pidx_q, pidx_d;
  logic [COEFF_COUNT-1:0] vbit_q, vbit_d;

  // working values after an optional clear by the first byte
  logic [KAPPA_W-1:0] k_eff;
  logic [PIDX_W-1:0]  start_idx;
  logic [SIGN_W-1:0]  cur_sign;
  logic [SCNT_W-1:0]  cur_scnt;
  logic [PIDX_W-1:0]  cur_pidx;
  logic               place;

  // read stage
  logic              s1_vld_q;
  logic [IDX_W-1:0]  s1_i_q, s1_i_d;
  logic [IDX_W-1:0]  s1_b_q;
  logic [VAL_W-1:0]  s1_sv_q, s1_sv_d;
  logic              s1_done_q, s1_done_d;
  logic              s1_vbit_q;

  // most recent pair, to cover writes the RAM read has not yet seen
  logic              byp_vld_q, byp_vld_d;
  logic [IDX_W-1:0]  byp_i_q;
  logic [IDX_W-1:0]  byp_b_q;
  logic [VAL_W-1:0]  byp_old_q;
  logic [VAL_W-1:0]  byp_sv_q;
  logic              wr2_q;

  // RAM
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic [VAL_W-1:0]  ram_rdata;
  logic [VAL_W-1:0]  old_val;

  // result queue
  logic   q_full;
  logic   q_valid;
  logic   q_half;
  pair_t  q_head;
  pair_t  push_pair;

  assign byte_b    = s_axis_tdata;
  // one position byte in the read stage at a time; the queue must have room
  assign s_axis_tready = !s1_vld_q && !q_full;
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign first_acc = in_acc && s_axis_tuser;

  // clamp kappa to 1..min(64, COEFF_COUNT)
  always_comb begin
    k_eff = kappa_q;
    if (kappa_q == '0) begin
      k_eff = KAPPA_W'(1);
    end else if (kappa_q > KAPPA_W'(LIM)) begin
      k_eff = KAPPA_W'(LIM);
    end
    start_idx = PIDX_END - PIDX_W'(k_eff);
  end

  always_comb begin
    cur_sign = s_axis_tuser ? '0 : sign_q;
    cur_scnt = s_axis_tuser ? '0 : scnt_q;
    cur_pidx = s_axis_tuser ? start_idx : pidx_q;

    sign_d    = sign_q;
    scnt_d    = scnt_q;
    pidx_d    = pidx_q;
    place     = 1'b0;
    s1_i_d    = cur_pidx[IDX_W-1:0];
    s1_sv_d   = cur_sign[0] ? COEFF_NEG : COEFF_POS;
    s1_done_d = (cur_pidx == PIDX_LAST);

    if (in_acc) begin
      sign_d = cur_sign;
      scnt_d = cur_scnt;
      pidx_d = cur_pidx;
      priority if (cur_scnt < SCNT_W'(SIGN_BYTES)) begin
        // fill the sign register, low byte first
        sign_d[cur_scnt[2:0]*BYTE_W +: BYTE_W] = byte_b;
        scnt_d = cur_scnt + SCNT_W'(1);
      end else if (cur_pidx >= PIDX_END) begin
        // challenge complete: drop the byte
      end else if ({1'b0, byte_b} > cur_pidx) begin
        // rejected candidate
      end else begin
        place  = 1'b1;
        sign_d = cur_sign >> 1;
        pidx_d = cur_pidx + PIDX_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Read stage: resolve old c[b], issue c[i] = old, queue the pair
  // --------------------------------------------------------------------------
  always_comb begin
    priority if (byp_vld_q && (byp_b_q == s1_b_q)) begin
      old_val = byp_sv_q;
    end else if (byp_vld_q && (byp_i_q == s1_b_q)) begin
      old_val = byp_old_q;
    end else if (s1_vbit_q) begin
      old_val = ram_rdata;
    end else begin
      old_val = COEFF_ZERO;
    end
  end

  // first write of the pair from the read stage, second in the following cycle;
  // a new challenge drops a second write still pending
  always_comb begin
    ram_we    = s1_vld_q || (wr2_q && !first_acc);
    ram_waddr = s1_vld_q ? s1_i_q[AW-1:0] : byp_b_q[AW-1:0];
    ram_wdata = s1_vld_q ? old_val : byp_sv_q;

    vbit_d = vbit_q;
    if (first_acc) begin
      vbit_d = '0;
    end else if (ram_we) begin
      vbit_d[ram_waddr] = 1'b1;
    end

    byp_vld_d = byp_vld_q;
    if (first_acc) begin
      byp_vld_d = 1'b0;
    end else if (s1_vld_q) begin
      byp_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kappa_q   <= KAPPA_W'(KAPPA_RST);
      sign_q    <= '0;
      scnt_q    <= '0;
      pidx_q    <= PIDX_RST;
      vbit_q    <= '0;
      s1_vld_q  <= 1'b0;
      byp_vld_q <= 1'b0;
      wr2_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        kappa_q <= cfg_wdata_i;
      end
      sign_q    <= sign_d;
      scnt_q    <= scnt_d;
      pidx_q    <= pidx_d;
      vbit_q    <= vbit_d;
      s1_vld_q  <= place;
      byp_vld_q <= byp_vld_d;
      wr2_q     <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (place) begin
      s1_i_q    <= s1_i_d;
      s1_b_q    <= byte_b;
      s1_sv_q   <= s1_sv_d;
      s1_done_q <= s1_done_d;
      s1_vbit_q <= vbit_q[byte_b[AW-1:0]];
    end
    if (s1_vld_q) begin
      byp_i_q   <= s1_i_q;
      byp_b_q   <= s1_b_q;
      byp_old_q <= old_val;
      byp_sv_q  <= s1_sv_q;
    end
  end

  scs_ram #(
    .WIDTH (VAL_W),
    .DEPTH (COEFF_COUNT)
  ) u_coeff_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (byte_b[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  always_comb begin
    push_pair.idx_a = s1_i_q;
    push_pair.val_a = old_val;
    push_pair.idx_b = s1_b_q;
    push_pair.val_b = s1_sv_q;
    push_pair.done  = s1_done_q;
  end

  scs_pair_fifo u_pair_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s1_vld_q),
    .pair_i  (push_pair),
    .pop_i   (m_axis_tvalid && m_axis_tready),
    .valid_o (q_valid),
    .half_o  (q_half),
    .full_o  (q_full),
    .head_o  (q_head)
  );

  // first item of a pair writes c[i], second writes c[b]
  assign m_axis_tvalid = q_valid;
  assign m_axis_tdata  = q_half ? {OUT_PAD'(0), q_head.val_b, q_head.idx_b}
                                : {OUT_PAD'(0), q_head.val_a, q_head.idx_a};
  assign m_axis_tlast  = q_half;
  assign m_axis_tuser  = q_head.done;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_one_write_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_vld_q && wr2_q))
    else $error("two RAM writes in one cycle");

  a_second_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |=> wr2_q)
    else $error("second write of a pair not scheduled");

  a_stall_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> !s_axis_tready)
    else $error("byte accepted while read stage busy");

  a_pidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pidx_q <= PIDX_END)
    else $error("place index beyond coefficient count");

endmodule

// ===== src/scs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scs_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/scs_pair_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_pair_fifo
// Two-deep queue of result pairs, drained one write per cycle while the consumer is ready.
// ----------------------------------------------------------------------------
module scs_pair_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  scs_pkg::pair_t  pair_i,
  input  logic            pop_i,
  output logic            valid_o,
  output logic            half_o,
  output logic            full_o,
  output scs_pkg::pair_t  head_o
);
  import scs_pkg::*;

  pair_t       pair_q [2];
  logic        wptr_q, wptr_d;
  logic        rptr_q, rptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        half_q, half_d;
  logic        pair_done;

  assign pair_done = pop_i && half_q;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    half_d = half_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      half_d = ~half_q;
    end
    if (pair_done) begin
      rptr_d = ~rptr_q;
    end
    unique case ({push_i, pair_done})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
      half_q <= 1'b0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
      half_q <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      pair_q[wptr_q] <= pair_i;
    end
  end

  assign valid_o = (cnt_q != 2'd0);
  assign half_o  = half_q;
  assign full_o  = (cnt_q == 2'd2);
  assign head_o  = pair_q[rptr_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != 2'd2))
    else $error("pair queue overflow");

endmodule
